FILE: rtl/fqmtb_pkg.sv
// Shared types and codes for the move-to-back queue.
`default_nettype none

package fqmtb_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADMIT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEUE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] item_key;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] served_key;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic            capture;
    logic            append_wr;
    logic            admit_rd;
    logic            admit_pop;
    logic            scan_start;
    logic            scan_step;
    logic            scan_check;
    logic            shift_wr;
    logic            tail_wr;
    logic            res_set;
    logic [ST_W-1:0] res_status;
    logic            out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             empty;
    logic             full;
    logic             match;
    logic             found;
    logic             last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/fifo_queue_move_to_back_core.sv
// Top level of the ordered queue with append, admit and move-to-back.
//
// Requests enter on in_valid_i / in_ready_o with in_data_i (command and
// item_key); each request gives exactly one result on out_valid_o /
// out_ready_i with out_data_o (status, served_key, occupancy).
// Entries live in a ring memory of DEPTH words addressed from a head
// pointer, so append and admit touch a single word.
// One request is worked on at a time. Append, unused codes, and admit or
// requeue on an empty queue are settled in the execute state; otherwise
// admit goes on through the admit state, and a requeue scans from the head
// and, if the key is found, writes it in the tail state. Each then waits in
// the response state, and the block returns to idle before the next request
// is taken. A requeue's length is set by the single read port of the ring
// memory: the search reads one entry a cycle from the head, and once the key
// is found each later entry is written back one place nearer the head before
// the key goes to the tail. in_ready_o is high only while no request is in
// progress. A finished result is held in an output register; while the
// receiver stalls, the next result waits in the block and no new request is
// taken. Reset empties the queue at once; the memory itself is not cleared.

`default_nettype none

module fifo_queue_move_to_back_core #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire fqmtb_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output fqmtb_pkg::out_t       out_data_o
);

  fqmtb_pkg::ctl_cmd_t ctl_cmd;
  fqmtb_pkg::dp_stat_t dp_stat;

  fqmtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  fqmtb_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .ctl_i      (ctl_cmd),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/fqmtb_datapath.sv
// Datapath of the move-to-back queue: ring memory, pointers, scan and result register.
`default_nettype none

module fqmtb_datapath #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire fqmtb_pkg::in_t       in_data_i,
  input  wire fqmtb_pkg::ctl_cmd_t  ctl_i,
  output fqmtb_pkg::dp_stat_t       stat_o,
  output fqmtb_pkg::out_t           out_data_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SB   = (KEY_BITS < fqmtb_pkg::KEY_W) ? KEY_BITS : fqmtb_pkg::KEY_W;
  localparam logic [IdxW:0]   DepthWrap = (IdxW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(DEPTH);

  logic [SB-1:0]   mem_q [DEPTH];
  logic [SB-1:0]   rd_data_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            found_q, found_d;
  logic [SB-1:0]   key_q;
  logic [fqmtb_pkg::CMD_W-1:0] cmd_q;
  logic [fqmtb_pkg::ST_W-1:0]  status_q;
  logic [fqmtb_pkg::KEY_W-1:0] served_q;
  fqmtb_pkg::out_t out_q;

  logic            we, re;
  logic [IdxW-1:0] wl, rl, wa, ra;
  logic [SB-1:0]   wd;
  logic [CntW-1:0] rd_pos;
  logic            match;

  // Logical position from the head to a physical slot of the ring.
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [IdxW-1:0] lidx);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= DepthWrap) begin
      sum = sum - DepthWrap;
    end
    return sum[IdxW-1:0];
  endfunction

  always_comb begin
    we = 1'b0;
    wl = '0;
    wd = key_q;
    if (ctl_i.append_wr) begin
      we = 1'b1;
      wl = IdxW'(count_q);
    end else if (ctl_i.shift_wr) begin
      // Once the key has been found, every later entry slides one place to the head.
      we = 1'b1;
      wl = rd_idx_q - IdxW'(1);
      wd = rd_data_q;
    end else if (ctl_i.tail_wr) begin
      we = 1'b1;
      wl = IdxW'(count_q - CntW'(1));
    end
    wa = phys(head_q, wl);
  end

  assign re = ctl_i.admit_rd | ctl_i.scan_start | ctl_i.scan_step;
  assign rl = (ctl_i.admit_rd || ctl_i.scan_start) ? '0 : rd_idx_q + IdxW'(1);
  assign ra = phys(head_q, rl);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem_q[ra];
    end
  end

  assign match  = (rd_data_q == key_q);
  assign rd_pos = CntW'(rd_idx_q) + CntW'(1);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    found_d  = found_q;
    if (ctl_i.append_wr) begin
      count_d = count_q + CntW'(1);
    end
    if (ctl_i.admit_pop) begin
      head_d  = phys(head_q, IdxW'(1));
      count_d = count_q - CntW'(1);
    end
    if (ctl_i.scan_start) begin
      rd_idx_d = '0;
      found_d  = 1'b0;
    end else if (ctl_i.scan_step) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
    if (ctl_i.scan_check && !found_q && match) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      found_q  <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q    <= in_data_i.command;
      key_q    <= SB'(in_data_i.item_key);
      served_q <= '0;
    end
    if (ctl_i.admit_pop) begin
      served_q <= fqmtb_pkg::KEY_W'(rd_data_q);
    end
    if (ctl_i.res_set) begin
      status_q <= ctl_i.res_status;
    end
    if (ctl_i.out_load) begin
      out_q.status     <= status_q;
      out_q.served_key <= served_q;
      out_q.occupancy  <= fqmtb_pkg::OCC_W'(count_q);
    end
  end

  assign stat_o.command = cmd_q;
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == DepthCnt);
  assign stat_o.match   = match;
  assign stat_o.found   = found_q;
  assign stat_o.last    = (rd_pos == count_q);
  assign out_data_o     = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("occupancy above queue depth");

  a_requeue_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.tail_wr |=> $stable(count_q))
    else $error("requeue changed the occupancy");

  a_admit_pops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.admit_pop |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("admit did not remove exactly one entry");

endmodule

`default_nettype wire

FILE: rtl/fqmtb_ctrl.sv
// Controller state machine of the move-to-back queue.
`default_nettype none

module fqmtb_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  input  wire fqmtb_pkg::dp_stat_t  stat_i,
  output fqmtb_pkg::ctl_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_ADMIT = 6'b000100,
    S_SCAN  = 6'b001000,
    S_TAIL  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_set = 1'b1;
        state_d       = S_RESP;
        case (stat_i.command)
          fqmtb_pkg::CMD_APPEND: begin
            if (stat_i.full) begin
              cmd_o.res_status = fqmtb_pkg::ST_FULL;
            end else begin
              cmd_o.append_wr  = 1'b1;
              cmd_o.res_status = fqmtb_pkg::ST_OK;
            end
          end
          fqmtb_pkg::CMD_ADMIT: begin
            if (stat_i.empty) begin
              cmd_o.res_status = fqmtb_pkg::ST_EMPTY;
            end else begin
              cmd_o.admit_rd = 1'b1;
              cmd_o.res_set  = 1'b0;
              state_d        = S_ADMIT;
            end
          end
          fqmtb_pkg::CMD_REQUEUE: begin
            if (stat_i.empty) begin
              cmd_o.res_status = fqmtb_pkg::ST_NOT_FOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
              cmd_o.res_set    = 1'b0;
              state_d          = S_SCAN;
            end
          end
          default: begin
            cmd_o.res_status = fqmtb_pkg::ST_OK;
          end
        endcase
      end
      S_ADMIT: begin
        cmd_o.admit_pop  = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = fqmtb_pkg::ST_OK;
        state_d          = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_check = 1'b1;
        cmd_o.shift_wr   = stat_i.found;
        if (stat_i.last) begin
          if (stat_i.found || stat_i.match) begin
            state_d = S_TAIL;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = fqmtb_pkg::ST_NOT_FOUND;
            state_d          = S_RESP;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_TAIL: begin
        cmd_o.tail_wr    = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = fqmtb_pkg::ST_OK;
        state_d          = S_RESP;
      end
      S_RESP: begin
        // The result register is free once the previous result has been taken.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response state");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && stat_i.last) |=> (state_q != S_SCAN))
    else $error("scan ran past the tail of the queue");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the move-to-back queue core.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned KEY_BITS    = 32;
  localparam logic [fqmtb_pkg::KEY_W-1:0] KEY_MASK =
    {fqmtb_pkg::KEY_W{1'b1}} >> (fqmtb_pkg::KEY_W - KEY_BITS);
  localparam logic [fqmtb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 2 * (DEPTH + 4);

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  fqmtb_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  fqmtb_pkg::out_t out_data;

  // Queue contents as the block should hold them, head first.
  logic [fqmtb_pkg::KEY_W-1:0] held_keys[$];
  fqmtb_pkg::out_t             pending_results[$];
  int unsigned      fail_count   = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      ready_hold   = 0;
  bit               idling_on    = 1'b1;

  always #5 clk_i = ~clk_i;

  fifo_queue_move_to_back_core #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Applies one request to the expected queue and returns the result it should give.
  function automatic fqmtb_pkg::out_t apply_request(fqmtb_pkg::in_t req);
    fqmtb_pkg::out_t             res;
    logic [fqmtb_pkg::KEY_W-1:0] key;
    int                          pos;
    res        = '0;
    res.status = fqmtb_pkg::ST_OK;
    key        = req.item_key & KEY_MASK;
    pos        = -1;
    case (req.command)
      fqmtb_pkg::CMD_APPEND: begin
        if (held_keys.size() >= DEPTH) begin
          res.status = fqmtb_pkg::ST_FULL;
        end else begin
          held_keys.push_back(key);
        end
      end
      fqmtb_pkg::CMD_ADMIT: begin
        if (held_keys.size() == 0) begin
          res.status = fqmtb_pkg::ST_EMPTY;
        end else begin
          res.served_key = held_keys.pop_front();
        end
      end
      fqmtb_pkg::CMD_REQUEUE: begin
        // Only the matching entry nearest the head moves.
        foreach (held_keys[i]) begin
          if (pos < 0 && held_keys[i] == key) pos = i;
        end
        if (pos < 0) begin
          res.status = fqmtb_pkg::ST_NOT_FOUND;
        end else begin
          held_keys.delete(pos);
          held_keys.push_back(key);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = fqmtb_pkg::OCC_W'(held_keys.size());
    return res;
  endfunction

  function automatic void compare_result(fqmtb_pkg::out_t got);
    fqmtb_pkg::out_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding: status %0d served_key %h occupancy %0d",
             got.status, got.served_key, got.occupancy);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      fail_count++;
    end
    if (got.served_key !== want.served_key) begin
      $error("served_key: expected %h, actual %h", want.served_key, got.served_key);
      fail_count++;
    end
    if (got.occupancy !== want.occupancy) begin
      $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
      fail_count++;
    end
  endfunction

  task automatic send_request(input fqmtb_pkg::in_t req);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(apply_request(req));
  endtask

  task automatic send_fields(input logic [fqmtb_pkg::CMD_W-1:0] cmd,
                             input logic [fqmtb_pkg::KEY_W-1:0] key);
    fqmtb_pkg::in_t req;
    req.command  = cmd;
    req.item_key = key;
    send_request(req);
  endtask

  // Weighted choice of command; requeue keys mostly come from the held entries
  // so that the search finds them, and appends reuse keys to make duplicates.
  function automatic fqmtb_pkg::in_t pick_request(int unsigned append_w, int unsigned admit_w,
                                                  int unsigned requeue_w);
    fqmtb_pkg::in_t req;
    int unsigned    total;
    int unsigned    roll;
    total        = append_w + admit_w + requeue_w;
    roll         = $urandom_range(0, total + 2);
    req.item_key = $urandom();
    if (roll < append_w) begin
      req.command = fqmtb_pkg::CMD_APPEND;
      if (held_keys.size() > 0 && $urandom_range(0, 3) == 0) begin
        req.item_key = held_keys[$urandom_range(0, held_keys.size() - 1)];
      end else if ($urandom_range(0, 2) == 0) begin
        req.item_key = $urandom_range(0, 7);
      end
    end else if (roll < append_w + admit_w) begin
      req.command = fqmtb_pkg::CMD_ADMIT;
    end else if (roll < total) begin
      req.command = fqmtb_pkg::CMD_REQUEUE;
      if (held_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
        req.item_key = held_keys[$urandom_range(0, held_keys.size() - 1)];
      end
    end else if (roll == total) begin
      req.command = CMD_UNUSED;
    end else begin
      req.command = fqmtb_pkg::CMD_REQUEUE;
    end
    return req;
  endfunction

  task automatic run_random(int unsigned count, int unsigned append_w, int unsigned admit_w,
                            int unsigned requeue_w);
    repeat (count) send_request(pick_request(append_w, admit_w, requeue_w));
  endtask

  task automatic test_directed();
    send_fields(fqmtb_pkg::CMD_ADMIT, $urandom());
    send_fields(fqmtb_pkg::CMD_REQUEUE, 32'h0000_0000);
    send_fields(CMD_UNUSED, 32'hFFFF_FFFF);
    send_fields(fqmtb_pkg::CMD_APPEND, 32'h0000_0000);
    send_fields(fqmtb_pkg::CMD_APPEND, 32'hFFFF_FFFF);
    send_fields(fqmtb_pkg::CMD_APPEND, 32'h0000_0000);
    send_fields(fqmtb_pkg::CMD_REQUEUE, 32'h0000_0000);
    send_fields(fqmtb_pkg::CMD_REQUEUE, 32'hFFFF_FFFF);
    send_fields(fqmtb_pkg::CMD_REQUEUE, 32'h5A5A_A5A5);
    send_fields(fqmtb_pkg::CMD_ADMIT, 32'hFFFF_FFFF);
    send_fields(CMD_UNUSED, $urandom());
    while (held_keys.size() < DEPTH) send_fields(fqmtb_pkg::CMD_APPEND, $urandom());
    send_fields(fqmtb_pkg::CMD_APPEND, 32'h1234_5678);
    send_fields(fqmtb_pkg::CMD_REQUEUE, held_keys[DEPTH / 2]);
  endtask

  task automatic test_filling();
    run_random(150, 60, 15, 25);
  endtask

  task automatic test_emptying();
    run_random(150, 20, 50, 30);
  endtask

  task automatic test_mixed();
    run_random(200, 35, 30, 35);
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    run_random(100, 35, 30, 35);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) compare_result(out_data);
    if (!idling_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run if neither channel moves a request or result for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_filling();
    test_emptying();
    test_mixed();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
